[rtl/mrgs_pkg.sv]
// ----------------------------------------------------------------------------
// Merge sorter package
// Shared types, sequencer step codes and the microcode table.
// ----------------------------------------------------------------------------
package mrgs_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int DATA_W        = 32;
    localparam int STEP_W        = 4;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_PASS,
        OP_RANGE,
        OP_MERGE,
        OP_COPY0,
        OP_COPY,
        OP_NEXTLO,
        OP_NEXTW,
        OP_EMIT0,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_LOAD_END,
        C_W_DONE,
        C_LO_DONE,
        C_NO_MERGE,
        C_RUN_END,
        C_EMIT_END
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  hold;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic load_end;
        logic w_done;
        logic lo_done;
        logic no_merge;
        logic run_end;
        logic emit_end;
    } t_status;

    localparam t_step S_LOAD   = 4'd0;
    localparam t_step S_INIT   = 4'd1;
    localparam t_step S_PASS   = 4'd2;
    localparam t_step S_RANGE  = 4'd3;
    localparam t_step S_CHECK  = 4'd4;
    localparam t_step S_MERGE  = 4'd5;
    localparam t_step S_COPY0  = 4'd6;
    localparam t_step S_COPY   = 4'd7;
    localparam t_step S_NEXTLO = 4'd8;
    localparam t_step S_NEXTW  = 4'd9;
    localparam t_step S_EMIT0  = 4'd10;
    localparam t_step S_EMIT   = 4'd11;

    // A taken condition jumps to the target; otherwise the step holds or advances.
    function automatic t_ctrl f_ucode(input t_step step);
        t_ctrl w;
        w = '{op: OP_NOP, cond: C_ALWAYS, hold: 1'b0, target: S_LOAD};
        case (step)
            S_LOAD:   w = '{op: OP_LOAD,   cond: C_LOAD_END, hold: 1'b1, target: S_INIT};
            S_INIT:   w = '{op: OP_INIT,   cond: C_NEVER,    hold: 1'b0, target: S_LOAD};
            S_PASS:   w = '{op: OP_PASS,   cond: C_W_DONE,   hold: 1'b0, target: S_EMIT0};
            S_RANGE:  w = '{op: OP_RANGE,  cond: C_LO_DONE,  hold: 1'b0, target: S_NEXTW};
            S_CHECK:  w = '{op: OP_NOP,    cond: C_NO_MERGE, hold: 1'b0, target: S_NEXTLO};
            S_MERGE:  w = '{op: OP_MERGE,  cond: C_RUN_END,  hold: 1'b1, target: S_COPY0};
            S_COPY0:  w = '{op: OP_COPY0,  cond: C_NEVER,    hold: 1'b0, target: S_LOAD};
            S_COPY:   w = '{op: OP_COPY,   cond: C_RUN_END,  hold: 1'b1, target: S_NEXTLO};
            S_NEXTLO: w = '{op: OP_NEXTLO, cond: C_ALWAYS,   hold: 1'b0, target: S_RANGE};
            S_NEXTW:  w = '{op: OP_NEXTW,  cond: C_ALWAYS,   hold: 1'b0, target: S_PASS};
            S_EMIT0:  w = '{op: OP_EMIT0,  cond: C_NEVER,    hold: 1'b0, target: S_LOAD};
            S_EMIT:   w = '{op: OP_EMIT,   cond: C_EMIT_END, hold: 1'b1, target: S_LOAD};
            default:  w = '{op: OP_NOP,    cond: C_ALWAYS,   hold: 1'b0, target: S_LOAD};
        endcase
        return w;
    endfunction

endpackage

[rtl/merge_sorter_unit.sv]
// ----------------------------------------------------------------------------
// Merge sorter unit
// Loads one item per cycle; a microcoded sequencer then sorts the N items of
// the batch bottom-up in ceil(log2 N) passes after a setup step. Each pass
// merges each pair of adjacent runs into the scratch memory and copies the
// merged run back; an unpaired tail run is left in place. After the last
// pass the items are emitted one per cycle while the receiver is ready.
// Synchronous active-low reset clears the sequencer, count, overflow flag
// and output valid; the element memories are not cleared.
// ----------------------------------------------------------------------------
module merge_sorter_unit #(
    parameter int MAX_ITEMS = mrgs_pkg::MAX_ITEMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [mrgs_pkg::DATA_W-1:0] i_value,
    input  logic                              i_is_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [mrgs_pkg::DATA_W-1:0] o_sorted_value,
    output logic                              o_is_final,
    output logic                              o_overflow
);

    mrgs_pkg::t_step   r_step, n_step;
    mrgs_pkg::t_ctrl   ctrl;
    mrgs_pkg::t_status status;
    logic              cond_hit;

    assign ctrl       = mrgs_pkg::f_ucode(r_step);
    assign o_in_ready = ctrl.op == mrgs_pkg::OP_LOAD;

    always_comb begin
        case (ctrl.cond)
            mrgs_pkg::C_NEVER:    cond_hit = 1'b0;
            mrgs_pkg::C_ALWAYS:   cond_hit = 1'b1;
            mrgs_pkg::C_LOAD_END: cond_hit = status.load_end;
            mrgs_pkg::C_W_DONE:   cond_hit = status.w_done;
            mrgs_pkg::C_LO_DONE:  cond_hit = status.lo_done;
            mrgs_pkg::C_NO_MERGE: cond_hit = status.no_merge;
            mrgs_pkg::C_RUN_END:  cond_hit = status.run_end;
            mrgs_pkg::C_EMIT_END: cond_hit = status.emit_end;
            default:              cond_hit = 1'b1;
        endcase
        if (cond_hit) begin
            n_step = ctrl.target;
        end else if (ctrl.hold) begin
            n_step = r_step;
        end else begin
            n_step = r_step + mrgs_pkg::t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= mrgs_pkg::S_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

    mrgs_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (ctrl.op),
        .i_in_valid     (i_in_valid),
        .i_value        (i_value),
        .i_is_last      (i_is_last),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_sorted_value (o_sorted_value),
        .o_is_final     (o_is_final),
        .o_overflow     (o_overflow),
        .o_status       (status)
    );

endmodule

[rtl/mrgs_datapath.sv]
// ----------------------------------------------------------------------------
// Merge sorter datapath
// Element store, merge scratch, run pointers and the output register.
// ----------------------------------------------------------------------------
module mrgs_datapath #(
    parameter int MAX_ITEMS = mrgs_pkg::MAX_ITEMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mrgs_pkg::t_op                     i_op,
    input  logic                              i_in_valid,
    input  logic signed [mrgs_pkg::DATA_W-1:0] i_value,
    input  logic                              i_is_last,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [mrgs_pkg::DATA_W-1:0] o_sorted_value,
    output logic                              o_is_final,
    output logic                              o_overflow,
    output mrgs_pkg::t_status                 o_status
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;

    logic signed [mrgs_pkg::DATA_W-1:0] m_store   [MAX_ITEMS];
    logic signed [mrgs_pkg::DATA_W-1:0] m_scratch [MAX_ITEMS];

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [WW-1:0] r_width;
    logic [CW-1:0] r_lo, r_mid, r_hi;
    logic [CW-1:0] r_left, r_right, r_dst;
    logic [CW-1:0] n_left, n_right, n_dst;

    logic signed [mrgs_pkg::DATA_W-1:0] r_rd_a, r_rd_b, r_sc;

    logic                              r_out_valid;
    logic signed [mrgs_pkg::DATA_W-1:0] r_out_value;
    logic                              r_out_final;
    logic                              r_out_ovf;

    logic [SW-1:0] sum_mid, sum_hi, n_sw;
    logic [CW-1:0] mid_c, hi_c;
    logic          load_acc, take_left, emit_take, emit_last, has_room;

    logic                              st_we;
    logic [AW-1:0]                     st_waddr;
    logic signed [mrgs_pkg::DATA_W-1:0] st_wdata;

    always_comb begin
        n_sw    = SW'(r_count);
        sum_mid = SW'(r_lo) + SW'(r_width);
        sum_hi  = SW'(r_lo) + SW'({r_width, 1'b0});
        mid_c   = (sum_mid >= n_sw) ? r_count : sum_mid[CW-1:0];
        hi_c    = (sum_hi >= n_sw) ? r_count : sum_hi[CW-1:0];

        has_room  = r_count < CW'(MAX_ITEMS);
        load_acc  = (i_op == mrgs_pkg::OP_LOAD) && i_in_valid;
        take_left = (r_left < r_mid) && ((r_right >= r_hi) || (r_rd_a < r_rd_b));
        emit_take = (i_op == mrgs_pkg::OP_EMIT) && (!r_out_valid || i_out_ready);
        emit_last = (r_left + CW'(1)) == r_count;

        o_status.load_end = load_acc && i_is_last;
        o_status.w_done   = r_width >= WW'(r_count);
        o_status.lo_done  = r_lo >= r_count;
        o_status.no_merge = r_mid >= r_hi;
        o_status.run_end  = (r_dst + CW'(1)) == r_hi;
        o_status.emit_end = emit_take && emit_last;
    end

    always_comb begin
        n_left  = r_left;
        n_right = r_right;
        n_dst   = r_dst;
        case (i_op)
            mrgs_pkg::OP_RANGE: begin
                n_left  = r_lo;
                n_right = mid_c;
                n_dst   = r_lo;
            end
            mrgs_pkg::OP_MERGE: begin
                n_dst = r_dst + CW'(1);
                if (take_left) begin
                    n_left = r_left + CW'(1);
                end else begin
                    n_right = r_right + CW'(1);
                end
            end
            mrgs_pkg::OP_COPY0: begin
                n_dst = r_lo;
            end
            mrgs_pkg::OP_COPY: begin
                n_dst = r_dst + CW'(1);
            end
            mrgs_pkg::OP_EMIT0: begin
                n_left = '0;
            end
            mrgs_pkg::OP_EMIT: begin
                if (emit_take) begin
                    n_left = r_left + CW'(1);
                end
            end
            default: begin
                n_left = r_left;
            end
        endcase
    end

    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_count[AW-1:0];
        st_wdata = i_value;
        if (load_acc && has_room) begin
            st_we = 1'b1;
        end else if (i_op == mrgs_pkg::OP_COPY) begin
            st_we    = 1'b1;
            st_waddr = r_dst[AW-1:0];
            st_wdata = r_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            m_store[st_waddr] <= st_wdata;
        end
        if (i_op == mrgs_pkg::OP_MERGE) begin
            m_scratch[r_dst[AW-1:0]] <= take_left ? r_rd_a : r_rd_b;
        end
        r_rd_a <= m_store[n_left[AW-1:0]];
        r_rd_b <= m_store[n_right[AW-1:0]];
        r_sc   <= m_scratch[n_dst[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
        r_dst   <= n_dst;
        case (i_op)
            mrgs_pkg::OP_INIT:   r_width <= WW'(1);
            mrgs_pkg::OP_NEXTW:  r_width <= {r_width[WW-2:0], 1'b0};
            mrgs_pkg::OP_PASS:   r_lo <= '0;
            mrgs_pkg::OP_NEXTLO: r_lo <= r_hi;
            mrgs_pkg::OP_RANGE: begin
                r_mid <= mid_c;
                r_hi  <= hi_c;
            end
            default: r_lo <= r_lo;
        endcase
        if (emit_take) begin
            r_out_value <= r_rd_a;
            r_out_final <= emit_last;
            r_out_ovf   <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_acc) begin
                if (has_room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (emit_take && emit_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (emit_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_is_final     = r_out_final;
    assign o_overflow     = r_out_ovf;

endmodule
